[src/clock_time_set_controller_unit_macros.svh]
// Assertion macros used by the time-set controller core.
`ifndef CLOCK_TIME_SET_CONTROLLER_UNIT_MACROS_SVH
`define CLOCK_TIME_SET_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on each rising clock edge outside reset.
`define CTSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on each rising clock edge, reset included.
`define CTSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CTSC_ASSERT(lbl, prop, msg)
`define CTSC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[src/ctsc_pkg.sv]
// Types and constants of the clock time-set controller.
package ctsc_pkg;

  // Event kinds
  localparam logic [1:0] EV_OTHER = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Button identifiers
  localparam logic [1:0] BTN_A     = 2'd0;
  localparam logic [1:0] BTN_B     = 2'd1;
  localparam logic [1:0] BTN_C     = 2'd2;
  localparam logic [1:0] BTN_OTHER = 2'd3;

  // Mode codes as seen on the result
  localparam logic [2:0] CODE_NORMAL  = 3'd0;
  localparam logic [2:0] CODE_HOUR    = 3'd1;
  localparam logic [2:0] CODE_MINUTE  = 3'd2;
  localparam logic [2:0] CODE_DAY     = 3'd3;
  localparam logic [2:0] CODE_MONTH   = 3'd4;
  localparam logic [2:0] CODE_YEAR    = 3'd5;
  localparam logic [2:0] CODE_WEEKDAY = 3'd6;

  // Settable mask reset value (all fields settable)
  localparam logic [4:0] MASK_RESET = 5'd31;

  // Field moduli
  localparam logic [8:0] HOUR_MOD    = 9'd24;
  localparam logic [8:0] MINUTE_MOD  = 9'd60;
  localparam logic [8:0] DAY_MOD     = 9'd31;
  localparam logic [8:0] MONTH_MOD   = 9'd12;
  localparam logic [8:0] YEAR_MOD    = 9'd99;
  localparam logic [8:0] WEEKDAY_MOD = 9'd7;

  // Display mode, one-hot
  typedef enum logic [6:0] {
    ST_NORMAL  = 7'b0000001,
    ST_HOUR    = 7'b0000010,
    ST_MINUTE  = 7'b0000100,
    ST_DAY     = 7'b0001000,
    ST_MONTH   = 7'b0010000,
    ST_YEAR    = 7'b0100000,
    ST_WEEKDAY = 7'b1000000
  } mode_t;

  // One input request
  typedef struct packed {
    logic [1:0] event_kind;
    logic [1:0] button_id;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [4:0] cur_day;
    logic [3:0] cur_month;
    logic [6:0] cur_year;
    logic [2:0] cur_weekday;
  } item_t;

  // One result
  typedef struct packed {
    logic [2:0] mode;
    logic       halt_clock;
    logic       resume_clock;
    logic       write_time;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
    logic [4:0] new_day;
    logic [3:0] new_month;
    logic [6:0] new_year;
    logic [2:0] new_weekday;
  } result_t;

endpackage

[src/ctsc_in_stage.sv]
// Input register: holds one accepted request until the core takes it.
module ctsc_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // hour[4:0], minute[10:5], day[15:11], month[19:16], year[26:20],
  // weekday[29:27], zero pad[31:30]
  input  logic [31:0]         s_tdata,
  // event_kind[1:0], button_id[3:2]
  input  logic [3:0]          s_tuser,
  input  logic                advance,
  output logic                held,
  output ctsc_pkg::item_t     item
);

  logic load;

  // Accept when empty or when the held request moves on this cycle
  assign s_tready = !held || advance;
  assign load     = s_tvalid && s_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (load) begin
      item.event_kind  <= s_tuser[1:0];
      item.button_id   <= s_tuser[3:2];
      item.cur_hour    <= s_tdata[4:0];
      item.cur_minute  <= s_tdata[10:5];
      item.cur_day     <= s_tdata[15:11];
      item.cur_month   <= s_tdata[19:16];
      item.cur_year    <= s_tdata[26:20];
      item.cur_weekday <= s_tdata[29:27];
    end
  end

endmodule

[src/ctsc_core.sv]
// Mode state, settable mask and the single-pass step logic.
`include "clock_time_set_controller_unit_macros.svh"

module ctsc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic                advance,
  input  ctsc_pkg::item_t     item,
  output ctsc_pkg::result_t   res
);

  ctsc_pkg::mode_t display_mode;
  ctsc_pkg::mode_t display_mode_next;
  logic [4:0]      settable_mask;

  logic            in_setting;
  logic            up;
  logic            down;
  logic [8:0]      hour_adj;
  logic [8:0]      minute_adj;
  logic [8:0]      day_adj;
  logic [8:0]      month_adj;
  logic [8:0]      year_adj;
  logic [8:0]      weekday_adj;

  // Reduce a small value modulo m; the value stays below four times m
  function automatic logic [8:0] mod_reduce(input logic [8:0] v, input logic [8:0] m);
    logic [8:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

  // Step applied to a field: +1, -1 (as m-1), or zero
  function automatic logic [8:0] step_of(input logic u, input logic d, input logic [8:0] m);
    logic [8:0] s;
    if (u) begin
      s = 9'd1;
    end else if (d) begin
      s = m - 9'd1;
    end else begin
      s = 9'd0;
    end
    return s;
  endfunction

  // Zero-based wrap over 0..m-1
  function automatic logic [8:0] wrap_zero(input logic [8:0] v, input logic u,
                                           input logic d, input logic [8:0] m);
    return mod_reduce(v + step_of(u, d, m), m);
  endfunction

  // One-based wrap over 1..m
  function automatic logic [8:0] wrap_one(input logic [8:0] v, input logic u,
                                          input logic d, input logic [8:0] m);
    return mod_reduce(v + m - 9'd1 + step_of(u, d, m), m) + 9'd1;
  endfunction

  // Next settable field after m, or back to hour
  function automatic ctsc_pkg::mode_t next_field(input ctsc_pkg::mode_t m,
                                                 input logic [4:0] mask);
    logic [4:0] above;
    ctsc_pkg::mode_t nf;
    unique case (m)
      ctsc_pkg::ST_HOUR:   above = 5'b11111;
      ctsc_pkg::ST_MINUTE: above = 5'b11110;
      ctsc_pkg::ST_DAY:    above = 5'b11100;
      ctsc_pkg::ST_MONTH:  above = 5'b11000;
      ctsc_pkg::ST_YEAR:   above = 5'b10000;
      default:             above = 5'b00000;
    endcase
    above = above & mask;
    priority if (above[0]) begin
      nf = ctsc_pkg::ST_MINUTE;
    end else if (above[1]) begin
      nf = ctsc_pkg::ST_DAY;
    end else if (above[2]) begin
      nf = ctsc_pkg::ST_MONTH;
    end else if (above[3]) begin
      nf = ctsc_pkg::ST_YEAR;
    end else if (above[4]) begin
      nf = ctsc_pkg::ST_WEEKDAY;
    end else begin
      nf = ctsc_pkg::ST_HOUR;
    end
    return nf;
  endfunction

  // Encode the one-hot mode to its output code
  function automatic logic [2:0] mode_code(input ctsc_pkg::mode_t m);
    logic [2:0] c;
    unique case (m)
      ctsc_pkg::ST_NORMAL:  c = ctsc_pkg::CODE_NORMAL;
      ctsc_pkg::ST_HOUR:    c = ctsc_pkg::CODE_HOUR;
      ctsc_pkg::ST_MINUTE:  c = ctsc_pkg::CODE_MINUTE;
      ctsc_pkg::ST_DAY:     c = ctsc_pkg::CODE_DAY;
      ctsc_pkg::ST_MONTH:   c = ctsc_pkg::CODE_MONTH;
      ctsc_pkg::ST_YEAR:    c = ctsc_pkg::CODE_YEAR;
      ctsc_pkg::ST_WEEKDAY: c = ctsc_pkg::CODE_WEEKDAY;
      default:              c = ctsc_pkg::CODE_NORMAL;
    endcase
    return c;
  endfunction

  // Hold the settable mask
  always_ff @(posedge clk) begin
    if (rst) begin
      settable_mask <= ctsc_pkg::MASK_RESET;
    end else if (cfg_wr_en) begin
      settable_mask <= cfg_wr_data;
    end
  end

  // Advance the display mode as each request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= ctsc_pkg::ST_NORMAL;
    end else if (advance) begin
      display_mode <= display_mode_next;
    end
  end

  assign in_setting = (display_mode != ctsc_pkg::ST_NORMAL);
  assign up         = (item.button_id == ctsc_pkg::BTN_B);
  assign down       = (item.button_id == ctsc_pkg::BTN_C);

  // Adjusted value of every field, selected below by the mode
  assign hour_adj    = wrap_zero({4'd0, item.cur_hour}, up, down, ctsc_pkg::HOUR_MOD);
  assign minute_adj  = wrap_zero({3'd0, item.cur_minute}, up, down, ctsc_pkg::MINUTE_MOD);
  assign day_adj     = wrap_one({4'd0, item.cur_day}, up, down, ctsc_pkg::DAY_MOD);
  assign month_adj   = wrap_one({5'd0, item.cur_month}, up, down, ctsc_pkg::MONTH_MOD);
  assign year_adj    = wrap_one({2'd0, item.cur_year}, up, down, ctsc_pkg::YEAR_MOD);
  assign weekday_adj = wrap_one({6'd0, item.cur_weekday}, up, down, ctsc_pkg::WEEKDAY_MOD);

  // Decide the event and build the result
  always_comb begin
    display_mode_next = display_mode;
    res               = '0;
    if (item.event_kind == ctsc_pkg::EV_LONG && item.button_id == ctsc_pkg::BTN_A) begin
      if (!in_setting) begin
        res.halt_clock    = 1'b1;
        display_mode_next = ctsc_pkg::ST_HOUR;
      end else begin
        res.resume_clock  = 1'b1;
        display_mode_next = ctsc_pkg::ST_NORMAL;
      end
    end else if (item.event_kind == ctsc_pkg::EV_SHORT && in_setting) begin
      if (item.button_id == ctsc_pkg::BTN_A) begin
        display_mode_next = next_field(display_mode, settable_mask);
      end else begin
        res.write_time  = 1'b1;
        res.new_hour    = item.cur_hour;
        res.new_minute  = item.cur_minute;
        res.new_day     = item.cur_day;
        res.new_month   = item.cur_month;
        res.new_year    = item.cur_year;
        res.new_weekday = item.cur_weekday;
        unique case (display_mode)
          ctsc_pkg::ST_HOUR:   res.new_hour   = hour_adj[4:0];
          ctsc_pkg::ST_MINUTE: res.new_minute = minute_adj[5:0];
          ctsc_pkg::ST_DAY:    res.new_day    = day_adj[4:0];
          ctsc_pkg::ST_MONTH:  res.new_month  = month_adj[3:0];
          ctsc_pkg::ST_YEAR:   res.new_year   = year_adj[6:0];
          default:             res.new_weekday = weekday_adj[2:0];
        endcase
      end
    end
    res.mode = mode_code(display_mode_next);
  end

  // Mode changes only when a request moves on
  `CTSC_ASSERT(a_mode_hold, !advance |=> $stable(display_mode), "mode changed without a request")
  // A halt pulse lands in hour mode, a resume pulse in normal mode
  `CTSC_ASSERT(a_halt_hour, advance && res.halt_clock |=> display_mode == ctsc_pkg::ST_HOUR,
               "halt did not enter hour mode")
  `CTSC_ASSERT(a_resume_norm,
               advance && res.resume_clock |=> display_mode == ctsc_pkg::ST_NORMAL,
               "resume did not return to normal mode")
  // A write never coincides with a mode toggle and only happens while setting
  `CTSC_ASSERT(a_write_excl,
               advance && res.write_time |-> in_setting && !res.halt_clock && !res.resume_clock,
               "write outside setting or with a toggle")

endmodule

[src/ctsc_out_stage.sv]
// Result register: holds one result until the downstream side takes it.
module ctsc_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  ctsc_pkg::result_t   res,
  output logic                out_free,
  output logic                m_tvalid,
  input  logic                m_tready,
  // new_hour[4:0], new_minute[10:5], new_day[15:11], new_month[19:16],
  // new_year[26:20], new_weekday[29:27], zero pad[31:30]
  output logic [31:0]         m_tdata,
  // mode[2:0], halt_clock[3], resume_clock[4], write_time[5]
  output logic [5:0]          m_tuser
);

  ctsc_pkg::result_t held_res;

  // Free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      held_res <= res;
    end
  end

  // Pack the result onto the stream
  assign m_tdata = {2'b00, held_res.new_weekday, held_res.new_year, held_res.new_month,
                    held_res.new_day, held_res.new_minute, held_res.new_hour};
  assign m_tuser = {held_res.write_time, held_res.resume_clock, held_res.halt_clock,
                    held_res.mode};

endmodule

[src/clock_time_set_controller_unit.sv]
// Clock time-set controller: button events in, mode and time writes out.
// A request accepted into the input register moves on to the result port once the result register has room.
// Throughput: one request per cycle while results are taken; the input and result registers each hold one.
// The mode update and field adjust are combinational between those two registers.
// Reset (rst, synchronous, active high) sets normal mode, all fields settable,
// and empties both registers.
module clock_time_set_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cur_hour[4:0], cur_minute[10:5], cur_day[15:11], cur_month[19:16],
  // cur_year[26:20], cur_weekday[29:27], zero pad[31:30]
  input  logic [31:0] s_tdata,
  // event_kind[1:0], button_id[3:2]
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // new_hour[4:0], new_minute[10:5], new_day[15:11], new_month[19:16],
  // new_year[26:20], new_weekday[29:27], zero pad[31:30]
  output logic [31:0] m_tdata,
  // mode[2:0], halt_clock[3], resume_clock[4], write_time[5]
  output logic [5:0]  m_tuser
);

  logic              held;
  logic              out_free;
  logic              advance;
  ctsc_pkg::item_t   item;
  ctsc_pkg::result_t res;

  // Move a held request on when the result register has room
  assign advance = held && out_free;

  ctsc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .held     (held),
    .item     (item)
  );

  ctsc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .res         (res)
  );

  ctsc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
